[design/assert_macros.svh]
// Assertion macros shared by the square perimeter spin map RTL.
// Depends on clk_i and rst_ni being in scope where a macro is used.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check that prop holds at every clock edge outside reset.
`define SPM_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error(msg);

// Check that cond at one edge implies res at the next edge.
`define SPM_ASSERT_NEXT(lbl, cond, res, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (cond) |=> (res)) \
    else $error(msg);

`endif

[design/spm_pkg.sv]
// Package for the square perimeter spin map: widths, register codes,
// reset values and the sideband record carried through the divider.
package spm_pkg;

  localparam int FRAC_BITS    = 16;
  localparam int WORD_BITS    = 32;
  localparam int SPIN_BITS    = FRAC_BITS + 4;
  localparam int CFG_IDX_BITS = 2;

  localparam int BASE_BITS = WORD_BITS + 5;
  localparam int SP_BITS   = WORD_BITS + 4;
  localparam int P_BITS    = WORD_BITS + 4;
  localparam int VAR_BITS  = WORD_BITS + 1;
  localparam int MUL1_BITS = 2 * WORD_BITS + 1;
  localparam int MAG_BITS  = 2 * WORD_BITS - 1;
  localparam int FIN_BITS  = WORD_BITS + 2;
  localparam int PROD_BITS = 2 * WORD_BITS + 2;

  typedef enum logic [CFG_IDX_BITS-1:0] {
    REG_WEIGHT     = 2'd0,
    REG_SPIN_INNER = 2'd1,
    REG_SPIN_OUTER = 2'd2,
    REG_SPACING    = 2'd3
  } cfg_reg_e;

  localparam logic [WORD_BITS-1:0] WEIGHT_RST     = WORD_BITS'(64'd1 << FRAC_BITS);
  localparam logic [SPIN_BITS-1:0] SPIN_INNER_RST = SPIN_BITS'(64'd4 << FRAC_BITS);

  typedef struct packed {
    logic                       zero;
    logic                       outer;
    logic                       x_fixed;
    logic                       fix_neg;
    logic                       q_neg;
    logic signed [VAR_BITS-1:0] vcoord;
    logic [WORD_BITS-1:0]       s;
  } spm_side_t;

endpackage

[design/spm_in_if.sv]
// Input channel of the square perimeter spin map: one point per word.
// Depends on spm_pkg for the word width.
interface spm_in_if;
  logic                                 valid;
  logic                                 ready;
  logic signed [spm_pkg::WORD_BITS-1:0] in_x;
  logic signed [spm_pkg::WORD_BITS-1:0] in_y;

  modport source (output valid, in_x, in_y, input ready);
  modport sink (input valid, in_x, in_y, output ready);
endinterface

[design/spm_out_if.sv]
// Output channel of the square perimeter spin map: one displacement per word.
// Depends on spm_pkg for the word width.
interface spm_out_if;
  logic                                 valid;
  logic                                 ready;
  logic signed [spm_pkg::WORD_BITS-1:0] delta_x;
  logic signed [spm_pkg::WORD_BITS-1:0] delta_y;

  modport source (output valid, delta_x, delta_y, input ready);
  modport sink (input valid, delta_x, delta_y, output ready);
endinterface

[design/square_perimeter_spin_map.sv]
// Square perimeter spin map: moves each point round the perimeter of the square
// of half-size max(|x|,|y|) and gives the weighted, saturated displacement.
// Depends on spm_pkg, spm_in_if, spm_out_if, spm_div and assert_macros.svh.
//
// One word is taken every cycle, and the 33-stage quotient pipeline of the
// radial spacing term makes up most of the pipeline's registers. A result
// waiting at the output holds the whole pipeline, and the input with it,
// until the word is taken.
// Registers: 0 weight, 1 spin_inner, 2 spin_outer, 3 spacing; write them idle.
`include "assert_macros.svh"

module square_perimeter_spin_map (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [spm_pkg::CFG_IDX_BITS-1:0]  cfg_idx_i,
  input  logic [spm_pkg::WORD_BITS-1:0]     cfg_data_i,
  spm_in_if.sink                            in_i,
  spm_out_if.source                         out_o
);
  import spm_pkg::*;

  localparam int W = WORD_BITS;

  logic signed [W-1:0]   weight_q, spacing_q;
  logic [SPIN_BITS-1:0]  spin_in_q, spin_out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      weight_q   <= WEIGHT_RST;
      spin_in_q  <= SPIN_INNER_RST;
      spin_out_q <= '0;
      spacing_q  <= '0;
    end else if (cfg_we_i) begin
      case (cfg_reg_e'(cfg_idx_i))
        REG_WEIGHT:     weight_q   <= cfg_data_i;
        REG_SPIN_INNER: spin_in_q  <= cfg_data_i[SPIN_BITS-1:0];
        REG_SPIN_OUTER: spin_out_q <= cfg_data_i[SPIN_BITS-1:0];
        REG_SPACING:    spacing_q  <= cfg_data_i;
        default:        weight_q   <= weight_q;
      endcase
    end
  end

  logic en;
  logic out_v_q;
  assign en       = !out_v_q || out_o.ready;
  assign in_i.ready = en;

  // stage 1: magnitudes, half-size, side base
  logic [W-1:0]                ax, ay, smax;
  logic                        outer_d, x_pos, y_pos;
  logic signed [BASE_BITS-1:0] s_e1, px_e, py_e, base_d;

  always_comb begin
    ax      = in_i.in_x[W-1] ? W'(-in_i.in_x) : W'(in_i.in_x);
    ay      = in_i.in_y[W-1] ? W'(-in_i.in_y) : W'(in_i.in_y);
    smax    = (ax > ay) ? ax : ay;
    outer_d = ($signed({1'b0, ax}) > $signed({weight_q[W-1], weight_q}))
           || ($signed({1'b0, ay}) > $signed({weight_q[W-1], weight_q}));
    x_pos   = !in_i.in_x[W-1] && (in_i.in_x != '0);
    y_pos   = !in_i.in_y[W-1] && (in_i.in_y != '0);
    s_e1    = $signed(BASE_BITS'(smax));
    px_e    = BASE_BITS'(in_i.in_x);
    py_e    = BASE_BITS'(in_i.in_y);
    if (ax > ay) begin
      base_d = x_pos ? s_e1 + py_e : (s_e1 <<< 2) + s_e1 - py_e;
    end else begin
      base_d = y_pos ? (s_e1 <<< 1) + s_e1 - px_e : (s_e1 <<< 3) - s_e1 + px_e;
    end
  end

  logic                        s1_v_q, s1_outer_q;
  logic [W-1:0]                s1_s_q;
  logic [SPIN_BITS-1:0]        s1_spin_q;
  logic signed [BASE_BITS-1:0] s1_base_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q <= 1'b0;
    end else if (en) begin
      s1_v_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      s1_s_q     <= smax;
      s1_outer_q <= outer_d;
      s1_spin_q  <= outer_d ? spin_out_q : spin_in_q;
      s1_base_q  <= base_d;
    end
  end

  // stage 2: spin advance
  logic [W+SPIN_BITS-1:0] sp_prod;
  assign sp_prod = (W+SPIN_BITS)'(s1_s_q) * (W+SPIN_BITS)'(s1_spin_q);

  logic                        s2_v_q, s2_outer_q;
  logic [W-1:0]                s2_s_q;
  logic [SP_BITS-1:0]          s2_sp_q;
  logic signed [BASE_BITS-1:0] s2_base_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_v_q <= 1'b0;
    end else if (en) begin
      s2_v_q <= s1_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      s2_s_q     <= s1_s_q;
      s2_outer_q <= s1_outer_q;
      s2_sp_q    <= sp_prod[W+SPIN_BITS-1:FRAC_BITS];
      s2_base_q  <= s1_base_q;
    end
  end

  // stage 3: perimeter position
  logic signed [BASE_BITS-1:0] p_d;
  assign p_d = s2_base_q + $signed(BASE_BITS'(s2_sp_q));

  logic              s3_v_q, s3_outer_q;
  logic [W-1:0]      s3_s_q;
  logic [P_BITS-1:0] s3_p_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s3_v_q <= 1'b0;
    end else if (en) begin
      s3_v_q <= s2_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      s3_s_q     <= s2_s_q;
      s3_outer_q <= s2_outer_q;
      s3_p_q     <= p_d[P_BITS-1:0];
    end
  end

  // stages 4 and 5: reduce modulo 8s
  logic [P_BITS-1:0] e3, e4, p4_d, p5_d;
  assign e3   = P_BITS'({s3_s_q, 3'b000});
  assign p4_d = (s3_p_q >= e3) ? s3_p_q - e3 : s3_p_q;

  logic              s4_v_q, s4_outer_q;
  logic [W-1:0]      s4_s_q;
  logic [P_BITS-1:0] s4_p_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s4_v_q <= 1'b0;
    end else if (en) begin
      s4_v_q <= s3_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      s4_s_q     <= s3_s_q;
      s4_outer_q <= s3_outer_q;
      s4_p_q     <= p4_d;
    end
  end

  assign e4   = P_BITS'({s4_s_q, 3'b000});
  assign p5_d = (s4_p_q >= e4) ? s4_p_q - e4 : s4_p_q;

  logic              s5_v_q, s5_outer_q;
  logic [W-1:0]      s5_s_q;
  logic [P_BITS-1:0] s5_p_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s5_v_q <= 1'b0;
    end else if (en) begin
      s5_v_q <= s4_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      s5_s_q     <= s4_s_q;
      s5_outer_q <= s4_outer_q;
      s5_p_q     <= p5_d;
    end
  end

  // stage 6: side of the square
  logic signed [BASE_BITS-1:0] s_e6, p_e6, mov6;
  spm_side_t                   side6_d;

  always_comb begin
    s_e6            = $signed(BASE_BITS'(s5_s_q));
    p_e6            = $signed(BASE_BITS'(s5_p_q));
    side6_d.zero    = (s5_s_q == '0);
    side6_d.outer   = s5_outer_q;
    side6_d.q_neg   = 1'b0;
    side6_d.s       = s5_s_q;
    if (p_e6 <= (s_e6 <<< 1)) begin
      side6_d.x_fixed = 1'b1;
      side6_d.fix_neg = 1'b0;
      mov6            = p_e6 - s_e6;
    end else if (p_e6 <= (s_e6 <<< 2)) begin
      side6_d.x_fixed = 1'b0;
      side6_d.fix_neg = 1'b0;
      mov6            = (s_e6 <<< 1) + s_e6 - p_e6;
    end else if (p_e6 <= (s_e6 <<< 2) + (s_e6 <<< 1)) begin
      side6_d.x_fixed = 1'b1;
      side6_d.fix_neg = 1'b1;
      mov6            = (s_e6 <<< 2) + s_e6 - p_e6;
    end else begin
      side6_d.x_fixed = 1'b0;
      side6_d.fix_neg = 1'b1;
      mov6            = p_e6 - ((s_e6 <<< 3) - s_e6);
    end
    side6_d.vcoord = mov6[VAR_BITS-1:0];
  end

  logic      s6_v_q;
  spm_side_t s6_side_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s6_v_q <= 1'b0;
    end else if (en) begin
      s6_v_q <= s5_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      s6_side_q <= side6_d;
    end
  end

  // stage 7: spacing product
  logic signed [MUL1_BITS-1:0] sprod_d;
  spm_side_t                   side7_d;
  assign sprod_d = s6_side_q.vcoord * spacing_q;

  always_comb begin
    side7_d       = s6_side_q;
    side7_d.q_neg = sprod_d[MUL1_BITS-1];
  end

  logic                        s7_v_q;
  spm_side_t                   s7_side_q;
  logic signed [MUL1_BITS-1:0] s7_prod_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s7_v_q <= 1'b0;
    end else if (en) begin
      s7_v_q <= s6_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      s7_side_q <= side7_d;
      s7_prod_q <= sprod_d;
    end
  end

  logic [MUL1_BITS-1:0] mag_full;
  logic                 div_v;
  logic [W-1:0]         div_q;
  spm_side_t            div_side;

  assign mag_full = s7_prod_q[MUL1_BITS-1] ? MUL1_BITS'(-s7_prod_q)
                                           : MUL1_BITS'(s7_prod_q);

  spm_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (s7_v_q),
    .mag_i   (mag_full[MAG_BITS-1:0]),
    .side_i  (s7_side_q),
    .valid_o (div_v),
    .quot_o  (div_q),
    .side_o  (div_side)
  );

  // stage 9: spaced coordinates
  logic signed [FIN_BITS-1:0] qs, var_e, vnew, s_f, grown, fixv, movv, x2_d, y2_d;

  always_comb begin
    qs    = $signed(FIN_BITS'(div_q));
    qs    = div_side.q_neg ? -qs : qs;
    var_e = FIN_BITS'(div_side.vcoord);
    vnew  = var_e + qs;
    s_f   = $signed(FIN_BITS'(div_side.s));
    grown = s_f + FIN_BITS'(spacing_q);
    if (div_side.outer) begin
      fixv = div_side.fix_neg ? -grown : grown;
      movv = vnew;
    end else begin
      fixv = div_side.fix_neg ? -s_f : s_f;
      movv = var_e;
    end
    x2_d = div_side.x_fixed ? fixv : movv;
    y2_d = div_side.x_fixed ? movv : fixv;
  end

  logic                       s9_v_q, s9_zero_q;
  logic signed [FIN_BITS-1:0] s9_x_q, s9_y_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s9_v_q <= 1'b0;
    end else if (en) begin
      s9_v_q <= div_v;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      s9_zero_q <= div_side.zero;
      s9_x_q    <= x2_d;
      s9_y_q    <= y2_d;
    end
  end

  // stage 10: weighting
  logic signed [PROD_BITS-1:0] wx_d, wy_d;
  assign wx_d = weight_q * s9_x_q;
  assign wy_d = weight_q * s9_y_q;

  logic                        s10_v_q, s10_zero_q;
  logic signed [PROD_BITS-1:0] s10_wx_q, s10_wy_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s10_v_q <= 1'b0;
    end else if (en) begin
      s10_v_q <= s9_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      s10_zero_q <= s9_zero_q;
      s10_wx_q   <= wx_d;
      s10_wy_q   <= wy_d;
    end
  end

  // output register: floor, saturate, zero at the origin
  localparam logic signed [PROD_BITS-1:0] SAT_MAX = PROD_BITS'((65'd1 << (W - 1)) - 65'd1);
  localparam logic signed [PROD_BITS-1:0] SAT_MIN = -(PROD_BITS'(65'd1 << (W - 1)));

  logic signed [PROD_BITS-1:0] shx, shy;
  logic signed [W-1:0]         dx_d, dy_d, dx_q, dy_q;

  always_comb begin
    shx = s10_wx_q >>> FRAC_BITS;
    shy = s10_wy_q >>> FRAC_BITS;
    if (s10_zero_q) begin
      dx_d = '0;
      dy_d = '0;
    end else begin
      dx_d = (shx > SAT_MAX) ? SAT_MAX[W-1:0] : (shx < SAT_MIN) ? SAT_MIN[W-1:0] : shx[W-1:0];
      dy_d = (shy > SAT_MAX) ? SAT_MAX[W-1:0] : (shy < SAT_MIN) ? SAT_MIN[W-1:0] : shy[W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q <= 1'b0;
    end else if (en) begin
      out_v_q <= s10_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      dx_q <= dx_d;
      dy_q <= dy_d;
    end
  end

  assign out_o.valid   = out_v_q;
  assign out_o.delta_x = dx_q;
  assign out_o.delta_y = dy_q;

  logic [W:0]        abs_spacing;
  logic [P_BITS:0]   p_limit;
  assign abs_spacing = spacing_q[W-1] ? (W+1)'(-$signed({1'b1, spacing_q}))
                                      : (W+1)'(spacing_q);
  assign p_limit     = (P_BITS+1)'({s3_s_q, 4'b0000}) + (P_BITS+1)'({s3_s_q, 3'b000});

  `SPM_ASSERT_NEXT(a_origin_zero, in_i.valid && in_i.ready && in_i.in_x == '0 && in_i.in_y == '0, s1_s_q == '0, "origin word lost its zero half-size")
  `SPM_ASSERT(a_p_range, !s3_v_q || s3_s_q == '0 || {1'b0, s3_p_q} < p_limit, "perimeter position beyond three turns")
  `SPM_ASSERT(a_quot_range, !div_v || div_side.zero || {1'b0, div_q} <= abs_spacing, "spacing quotient exceeds spacing")

endmodule

[design/spm_div.sv]
// Pipelined restoring divider of the spin map: an input register, then one quotient bit per stage.
// Depends on spm_pkg for widths and the sideband record.
module spm_div (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           en_i,
  input  logic                           valid_i,
  input  logic [spm_pkg::MAG_BITS-1:0]   mag_i,
  input  spm_pkg::spm_side_t             side_i,
  output logic                           valid_o,
  output logic [spm_pkg::WORD_BITS-1:0]  quot_o,
  output spm_pkg::spm_side_t             side_o
);
  import spm_pkg::*;

  localparam int NST = WORD_BITS + 1;

  logic                 v_q    [NST];
  logic [WORD_BITS-1:0] rem_q  [NST];
  logic [WORD_BITS-1:0] lo_q   [NST];
  logic [WORD_BITS-1:0] quot_q [NST];
  spm_side_t            side_q [NST];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q[0] <= 1'b0;
    end else if (en_i) begin
      v_q[0] <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rem_q[0]  <= WORD_BITS'(mag_i[MAG_BITS-1:WORD_BITS]);
      lo_q[0]   <= mag_i[WORD_BITS-1:0];
      quot_q[0] <= '0;
      side_q[0] <= side_i;
    end
  end

  for (genvar k = 1; k < NST; k++) begin : g_step
    logic [WORD_BITS:0] trial;
    logic               ge;

    always_comb begin
      trial = {rem_q[k-1], lo_q[k-1][WORD_BITS-1]};
      ge    = trial >= {1'b0, side_q[k-1].s};
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q[k] <= 1'b0;
      end else if (en_i) begin
        v_q[k] <= v_q[k-1];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[k]  <= ge ? WORD_BITS'(trial - {1'b0, side_q[k-1].s}) : WORD_BITS'(trial);
        lo_q[k]   <= {lo_q[k-1][WORD_BITS-2:0], 1'b0};
        quot_q[k] <= {quot_q[k-1][WORD_BITS-2:0], ge};
        side_q[k] <= side_q[k-1];
      end
    end
  end

  assign valid_o = v_q[NST-1];
  assign quot_o  = quot_q[NST-1];
  assign side_o  = side_q[NST-1];

endmodule
